@@ sv/shortest_seek_first_scheduler_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the shortest-seek-first scheduler checks
// Shared property forms: overlapped and next-cycle implication under reset.
// ----------------------------------------------------------------------------
`ifndef SHORTEST_SEEK_FIRST_SCHEDULER_CORE_MACROS_SVH
`define SHORTEST_SEEK_FIRST_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SSTF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sstf check failed");

// Next-cycle implication, disabled while reset is held.
`define SSTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sstf check failed");

// Next-cycle implication that also covers the reset cycles.
`define SSTF_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sstf check failed");

`endif

@@ sv/sstf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared widths, codes and helpers of the shortest-seek-first scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

  localparam int TRACK_W     = 7;
  localparam int TRACK_COUNT = 128;

  // Item mode codes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_START = 1'b1;

  // Control from the sequencer to the nearest-track search unit
  typedef struct packed {
    logic clear;     // drop the current best, start a new pass
    logic cand_vld;  // a read word is an unserved candidate
  } pick_ctl_t;

  // Saturate a track or head value to the track range.
  function automatic logic [TRACK_W-1:0] clamp_track(input logic [TRACK_W-1:0] v);
    logic [TRACK_W-1:0] res;
    res = v;
    if (int'(v) > TRACK_COUNT - 1) begin
      res = TRACK_W'(TRACK_COUNT - 1);
    end
    return res;
  endfunction

endpackage

@@ sv/sstf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_in_if / sstf_out_if
// Valid/ready channels for request words and schedule words.
// ----------------------------------------------------------------------------
interface sstf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [sstf_pkg::TRACK_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface sstf_out_if;
  logic                        valid;
  logic                        ready;
  logic [sstf_pkg::TRACK_W-1:0] track;
  logic                        last;
  logic                        dropped;

  modport source (output valid, output track, output last, output dropped, input ready);
  modport sink   (input valid, input track, input last, input dropped, output ready);
endinterface

@@ sv/shortest_seek_first_scheduler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_seek_first_scheduler_core
// Shortest-seek-first track scheduler around a small request memory.
// ----------------------------------------------------------------------------
//  channel   dir  handshake    word
//  in_ch     in   valid/ready  mode, value (track to load, or head to start)
//  out_ch    out  valid/ready  track, last, dropped
//
//  A start word with stored requests begins a run that gives one result per full
//  sweep of the memory read port (one entry a cycle, through the registered read
//  data into the best-so-far register of the search unit).
//  Reset clears the count, the served marks, the overflow flag and the output.
//  A stalled output holds the search at its end; no word is taken during a run.
// ----------------------------------------------------------------------------
module shortest_seek_first_scheduler_core #(
  parameter int MAX_REQUESTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  sstf_in_if.sink           in_ch,
  sstf_out_if.source        out_ch
);

  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W = $clog2(MAX_REQUESTS);
  localparam int TW    = sstf_pkg::TRACK_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } sstf_state_t;

  sstf_state_t state_r, state_nxt;

  // Control state
  logic [CNT_W-1:0]        count_r, count_nxt;       // stored requests
  logic                    overflow_r, overflow_nxt; // a load was dropped
  logic [MAX_REQUESTS-1:0] served_r, served_nxt;     // one mark per entry
  logic [CNT_W-1:0]        idx_r, idx_nxt;           // sweep read address
  logic [CNT_W-1:0]        k_r, k_nxt;               // results emitted so far
  logic                    vld_d_r;                  // read data valid
  logic                    out_valid_r, out_valid_nxt;

  // Payload
  logic [IDX_W-1:0] idx_d_r;
  logic [TW-1:0]    head_r, head_nxt;
  logic             drop_r, drop_nxt;
  logic [TW-1:0]    out_track_r, out_track_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_dropped_r, out_dropped_nxt;

  logic             in_acc;
  logic [TW-1:0]    in_val;
  logic             out_free;
  logic             store_full;
  logic             load_wr;
  logic             issue;
  logic             scan_done;
  logic             emit;
  logic             emit_last;
  logic [TW-1:0]    rd_track;
  logic [TW-1:0]    best_track;
  logic [IDX_W-1:0] best_idx;
  sstf_pkg::pick_ctl_t pick_ctl;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign in_val     = sstf_pkg::clamp_track(in_ch.value);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign store_full = (count_r == CNT_W'(MAX_REQUESTS));
  assign load_wr    = in_acc && (in_ch.mode == sstf_pkg::MODE_LOAD) && !store_full;

  // Take words only between runs, and only when a drop report has room.
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;

  // Sweep: issue one read a cycle, then drain the read latency.
  assign issue     = (state_r == ST_SCAN) && (idx_r < count_r);
  assign scan_done = (state_r == ST_SCAN) && (idx_r == count_r) && !vld_d_r;
  assign emit      = scan_done && out_free;
  assign emit_last = emit && (k_r == count_r - CNT_W'(1));

  // Restart the search on each start and after each emitted result.
  assign pick_ctl.clear    = emit || (in_acc && (in_ch.mode == sstf_pkg::MODE_START));
  assign pick_ctl.cand_vld = vld_d_r && !served_r[idx_d_r];

  sstf_store #(
    .DEPTH  (MAX_REQUESTS),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (in_val),
    .rd_en   (issue),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_data (rd_track)
  );

  sstf_pick #(
    .IDX_W (IDX_W)
  ) u_pick (
    .clk        (clk),
    .ctl        (pick_ctl),
    .head       (head_r),
    .cand_track (rd_track),
    .cand_idx   (idx_d_r),
    .best_track (best_track),
    .best_idx   (best_idx)
  );

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    overflow_nxt    = overflow_r;
    served_nxt      = served_r;
    idx_nxt         = idx_r;
    k_nxt           = k_r;
    head_nxt        = head_r;
    drop_nxt        = drop_r;
    out_valid_nxt   = out_valid_r;
    out_track_nxt   = out_track_r;
    out_last_nxt    = out_last_r;
    out_dropped_nxt = out_dropped_r;

    // Release the output word once taken; a new word below overrides this.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (issue) begin
      idx_nxt = idx_r + CNT_W'(1);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.mode == sstf_pkg::MODE_LOAD) begin
            if (!store_full) begin
              count_nxt = count_r + CNT_W'(1);
            end else begin
              // Full store: drop the request and report it.
              overflow_nxt    = 1'b1;
              out_valid_nxt   = 1'b1;
              out_track_nxt   = in_val;
              out_last_nxt    = 1'b0;
              out_dropped_nxt = 1'b1;
            end
          end else begin
            head_nxt = in_val;
            drop_nxt = overflow_r;
            if (count_r == '0) begin
              overflow_nxt = 1'b0;
            end else begin
              state_nxt = ST_SCAN;
              idx_nxt   = '0;
              k_nxt     = '0;
            end
          end
        end
      end
      ST_SCAN: begin
        if (emit) begin
          out_valid_nxt        = 1'b1;
          out_track_nxt        = best_track;
          out_last_nxt         = emit_last;
          out_dropped_nxt      = drop_r;
          served_nxt[best_idx] = 1'b1;
          head_nxt             = best_track;
          if (emit_last) begin
            // Run complete: empty the store.
            state_nxt    = ST_IDLE;
            count_nxt    = '0;
            overflow_nxt = 1'b0;
            served_nxt   = '0;
          end else begin
            k_nxt   = k_r + CNT_W'(1);
            idx_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      overflow_r  <= 1'b0;
      served_r    <= '0;
      idx_r       <= '0;
      k_r         <= '0;
      vld_d_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      overflow_r  <= overflow_nxt;
      served_r    <= served_nxt;
      idx_r       <= idx_nxt;
      k_r         <= k_nxt;
      vld_d_r     <= issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_d_r       <= idx_r[IDX_W-1:0];
    head_r        <= head_nxt;
    drop_r        <= drop_nxt;
    out_track_r   <= out_track_nxt;
    out_last_r    <= out_last_nxt;
    out_dropped_r <= out_dropped_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.track   = out_track_r;
  assign out_ch.last    = out_last_r;
  assign out_ch.dropped = out_dropped_r;

endmodule

@@ sv/sstf_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_store
// Request memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sstf_store #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [sstf_pkg::TRACK_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [sstf_pkg::TRACK_W-1:0] rd_data
);

  logic [sstf_pkg::TRACK_W-1:0] mem [DEPTH];
  logic [sstf_pkg::TRACK_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/sstf_pick.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_pick
// Nearest-track search: compare one candidate a cycle against the best so far.
// ----------------------------------------------------------------------------
module sstf_pick #(
  parameter int IDX_W = 4
) (
  input  logic                         clk,
  input  sstf_pkg::pick_ctl_t          ctl,
  input  logic [sstf_pkg::TRACK_W-1:0] head,
  input  logic [sstf_pkg::TRACK_W-1:0] cand_track,
  input  logic [IDX_W-1:0]             cand_idx,
  output logic [sstf_pkg::TRACK_W-1:0] best_track,
  output logic [IDX_W-1:0]             best_idx
);

  logic                         found_r;
  logic                         found_nxt;
  logic [sstf_pkg::TRACK_W-1:0] best_d_r;
  logic [sstf_pkg::TRACK_W-1:0] best_track_r;
  logic [IDX_W-1:0]             best_idx_r;
  logic [sstf_pkg::TRACK_W-1:0] cand_d;
  logic                         better;

  assign cand_d = (cand_track >= head) ? (cand_track - head) : (head - cand_track);

  // Strictly nearer wins; equal distance goes to the lower track; equal track keeps
  // the earlier entry.
  assign better = ctl.cand_vld &&
                  (!found_r || (cand_d < best_d_r) ||
                   ((cand_d == best_d_r) && (cand_track < best_track_r)));

  always_comb begin
    found_nxt = found_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (better) begin
      found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    if (better && !ctl.clear) begin
      best_d_r     <= cand_d;
      best_track_r <= cand_track;
      best_idx_r   <= cand_idx;
    end
  end

  assign best_track = best_track_r;
  assign best_idx   = best_idx_r;

endmodule

@@ sv/sstf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "shortest_seek_first_scheduler_core_macros.svh"

module sstf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [sstf_pkg::TRACK_W-1:0] out_track,
  input logic                         out_last,
  input logic                         out_dropped
);

  // A stalled result word holds.
  `SSTF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_track) && $stable(out_last) && $stable(out_dropped))

  // Reset empties the output register.
  `SSTF_ASSERT_ALWAYS_NEXT(a_rst_out, clk, !rst_n, !out_valid)

  // Once the final word of a schedule is taken, the block takes words again.
  `SSTF_ASSERT_NEXT(a_last_idle, clk, rst_n, out_valid && out_ready && out_last, in_ready)

  // While idle with no word taken, no result appears.
  `SSTF_ASSERT_NEXT(a_no_spurious, clk, rst_n, in_ready && !in_valid && !out_valid, !out_valid)

endmodule

bind shortest_seek_first_scheduler_core sstf_checker u_sstf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_track   (out_ch.track),
  .out_last    (out_ch.last),
  .out_dropped (out_ch.dropped)
);

@@ sim/tb_shortest_seek_first_scheduler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shortest_seek_first_scheduler_core
// Self-checking bench for the shortest-seek-first track scheduler.
// A short table of request and start words is walked first: an empty start,
// single-track schedules from both ends of the disk, a full store with
// drops, ties and duplicate tracks. It is followed by random bursts of loads,
// each closed by a start. A scheduling predictor builds the expected schedule
// words, and every word leaving the block is compared with the oldest
// expectation. Both sides idle at random. The sink holds off once for a long
// stretch, so the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_shortest_seek_first_scheduler_core;

  localparam int MAX_REQ      = 16;
  localparam int TW           = sstf_pkg::TRACK_W;
  localparam int TOTAL_ITEMS  = 270;
  localparam int DIR_ROWS     = 24;
  localparam int MAX_GAP      = 16;
  // Worst case for one start: MAX_REQ results, each after a full sweep of the store.
  localparam int DRAIN_CYCLES = MAX_REQ * (MAX_REQ + 2) + 64;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AFTER   = 120;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [TW-1:0] track;
    logic          last;
    logic          dropped;
  } sched_word_t;

  // How a table row is checked: against the predictor, by a typed answer, or not at all
  typedef enum logic [1:0] {
    ROW_MODEL  = 2'd0,
    ROW_SILENT = 2'd1,
    ROW_TYPED  = 2'd2
  } row_kind_t;

  typedef struct packed {
    logic          mode;
    logic [TW-1:0] value;
    row_kind_t     kind;
    sched_word_t   typed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sstf_in_if  in_ch ();
  sstf_out_if out_ch ();

  shortest_seek_first_scheduler_core #(
    .MAX_REQUESTS (MAX_REQ)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Predictor state: pending requests, their count and the drop flag
  logic [TW-1:0] req_tracks [MAX_REQ];
  int            req_count;
  bit            req_overflow;

  // Schedule words still owed by the block, oldest first
  sched_word_t sched_expect [$];

  int  mismatches;
  int  items_sent;
  int  loads_sent;
  int  starts_sent;
  int  drops_seen;
  int  words_checked;
  bit  src_calm;
  bit  snk_calm;
  int  snk_wait;
  logic long_hold = 1'b0;

  // Directed words. Typed answers only where they are plain to see.
  stim_row_t dir_table [DIR_ROWS] = '{
    // start on an empty store straight after reset: nothing comes out
    '{sstf_pkg::MODE_START, 7'd0,   ROW_SILENT, '{7'd0,   1'b0, 1'b0}},
    // one request at each end of the disk, head at the other end
    '{sstf_pkg::MODE_LOAD,  7'd127, ROW_SILENT, '{7'd0,   1'b0, 1'b0}},
    '{sstf_pkg::MODE_START, 7'd0,   ROW_TYPED,  '{7'd127, 1'b1, 1'b0}},
    '{sstf_pkg::MODE_LOAD,  7'd0,   ROW_SILENT, '{7'd0,   1'b0, 1'b0}},
    '{sstf_pkg::MODE_START, 7'd127, ROW_TYPED,  '{7'd0,   1'b1, 1'b0}},
    // fill the store: duplicates, both ends, a tie around head 64
    '{sstf_pkg::MODE_LOAD,  7'd0,   ROW_SILENT, '{7'd0,   1'b0, 1'b0}},
    '{sstf_pkg::MODE_LOAD,  7'd127, ROW_SILENT, '{7'd0,   1'b0, 1'b0}},
    '{sstf_pkg::MODE_LOAD,  7'd60,  ROW_SILENT, '{7'd0,   1'b0, 1'b0}},
    '{sstf_pkg::MODE_LOAD,  7'd68,  ROW_SILENT, '{7'd0,   1'b0, 1'b0}},
    '{sstf_pkg::MODE_LOAD,  7'd60,  ROW_SILENT, '{7'd0,   1'b0, 1'b0}},
    '{sstf_pkg::MODE_LOAD,  7'd5,   ROW_SILENT, '{7'd0,   1'b0, 1'b0}},
    '{sstf_pkg::MODE_LOAD,  7'd100, ROW_SILENT, '{7'd0,   1'b0, 1'b0}},
    '{sstf_pkg::MODE_LOAD,  7'd33,  ROW_SILENT, '{7'd0,   1'b0, 1'b0}},
    '{sstf_pkg::MODE_LOAD,  7'd33,  ROW_SILENT, '{7'd0,   1'b0, 1'b0}},
    '{sstf_pkg::MODE_LOAD,  7'd90,  ROW_SILENT, '{7'd0,   1'b0, 1'b0}},
    '{sstf_pkg::MODE_LOAD,  7'd12,  ROW_SILENT, '{7'd0,   1'b0, 1'b0}},
    '{sstf_pkg::MODE_LOAD,  7'd127, ROW_SILENT, '{7'd0,   1'b0, 1'b0}},
    '{sstf_pkg::MODE_LOAD,  7'd71,  ROW_SILENT, '{7'd0,   1'b0, 1'b0}},
    '{sstf_pkg::MODE_LOAD,  7'd45,  ROW_SILENT, '{7'd0,   1'b0, 1'b0}},
    '{sstf_pkg::MODE_LOAD,  7'd1,   ROW_SILENT, '{7'd0,   1'b0, 1'b0}},
    '{sstf_pkg::MODE_LOAD,  7'd126, ROW_SILENT, '{7'd0,   1'b0, 1'b0}},
    // store full: both loads are dropped and echoed back with the flag
    '{sstf_pkg::MODE_LOAD,  7'd127, ROW_TYPED,  '{7'd127, 1'b0, 1'b1}},
    '{sstf_pkg::MODE_LOAD,  7'd0,   ROW_TYPED,  '{7'd0,   1'b0, 1'b1}},
    // full schedule from mid-disk, every word flagged as after a drop
    '{sstf_pkg::MODE_START, 7'd64,  ROW_MODEL,  '{7'd0,   1'b0, 1'b0}}
  };

  // Draw an idle gap; now and then toggle into or out of a calm stretch.
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 15) == 0) begin
      calm = ~calm;
    end
    return calm ? 0 : int'($urandom_range(0, MAX_GAP));
  endfunction

  function automatic void report_mismatch(input string what);
    if (mismatches < 100) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatches++;
  endfunction

  // Advance the predictor by one accepted word and return the schedule it owes.
  function automatic void predict_schedule(input logic mode, input logic [TW-1:0] value,
                                           output sched_word_t words [$]);
    sched_word_t   w;
    bit            served [MAX_REQ];
    logic [TW-1:0] head;
    int            pick;
    int            best_d;
    int            d;
    bit            found;
    words = {};
    // 7-bit values never exceed the last track, so no saturation is needed.
    if (mode == sstf_pkg::MODE_LOAD) begin
      if (req_count < MAX_REQ) begin
        req_tracks[req_count] = value;
        req_count++;
      end else begin
        req_overflow = 1'b1;
        w.track   = value;
        w.last    = 1'b0;
        w.dropped = 1'b1;
        words.push_back(w);
      end
      return;
    end
    served = '{default: 1'b0};
    head   = value;
    for (int k = 0; k < req_count; k++) begin
      found  = 1'b0;
      pick   = 0;
      best_d = 0;
      for (int i = 0; i < req_count; i++) begin
        if (!served[i]) begin
          d = (req_tracks[i] > head) ? int'(req_tracks[i] - head) : int'(head - req_tracks[i]);
          // nearest wins; on equal distance the lower track, then store order
          if (!found || d < best_d || (d == best_d && req_tracks[i] < req_tracks[pick])) begin
            found  = 1'b1;
            pick   = i;
            best_d = d;
          end
        end
      end
      served[pick] = 1'b1;
      head         = req_tracks[pick];
      w.track      = head;
      w.last       = (k == req_count - 1);
      w.dropped    = req_overflow;
      words.push_back(w);
    end
    req_count    = 0;
    req_overflow = 1'b0;
  endfunction

  // Offer one word, hold it until taken, then book what it should produce.
  task automatic send_word(input logic mode, input logic [TW-1:0] value,
                           input row_kind_t kind, input sched_word_t typed);
    int          gap;
    sched_word_t words [$];
    gap = draw_gap(src_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (mode == sstf_pkg::MODE_LOAD) begin
      loads_sent++;
    end else begin
      starts_sent++;
    end
    predict_schedule(mode, value, words);
    case (kind)
      ROW_MODEL: begin
        foreach (words[i]) sched_expect.push_back(words[i]);
      end
      ROW_TYPED: begin
        sched_expect.push_back(typed);
      end
      default: begin
      end
    endcase
  endtask

  // Compare one accepted schedule word with the oldest expectation.
  function automatic void check_word(input sched_word_t got);
    sched_word_t want;
    if (got.dropped) begin
      drops_seen++;
    end
    if (sched_expect.size() == 0) begin
      report_mismatch($sformatf("unexpected word track=%0d last=%0b dropped=%0b",
                                got.track, got.last, got.dropped));
      return;
    end
    want = sched_expect.pop_front();
    words_checked++;
    if (got.track !== want.track || got.last !== want.last || got.dropped !== want.dropped) begin
      report_mismatch($sformatf("track %0d/%0d last %0b/%0b dropped %0b/%0b (got/exp)",
                                got.track, want.track, got.last, want.last,
                                got.dropped, want.dropped));
    end
  endfunction

  // Sink side: take schedule words, idling a random gap after each one.
  always @(posedge clk) begin : sink_side
    int          gap;
    sched_word_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      snk_wait     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.track   = out_ch.track;
        got.last    = out_ch.last;
        got.dropped = out_ch.dropped;
        check_word(got);
        gap = draw_gap(snk_calm);
        snk_wait     <= gap;
        out_ch.ready <= (gap == 0) && !long_hold;
      end else begin
        if (snk_wait > 0) begin
          snk_wait <= snk_wait - 1;
        end
        out_ch.ready <= (snk_wait <= 1) && !long_hold;
      end
    end
  end

  // Long sink hold-off while the source keeps offering: fill the block and
  // stall its input.
  initial begin
    wait (items_sent >= HOLD_AFTER);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_shortest_seek_first_scheduler_core: FAIL");
    $finish;
  end

  // Main stimulus
  initial begin : stimulus
    int            burst;
    int            r;
    int            v;
    int            base;
    logic [TW-1:0] head;
    sched_word_t   none;
    in_ch.valid  = 1'b0;
    in_ch.mode   = sstf_pkg::MODE_LOAD;
    in_ch.value  = '0;
    none         = '0;
    mismatches   = 0;
    items_sent   = 0;
    loads_sent   = 0;
    starts_sent  = 0;
    drops_seen   = 0;
    words_checked = 0;
    req_count    = 0;
    req_overflow = 1'b0;
    src_calm     = 1'b0;
    snk_calm     = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(dir_table[i].mode, dir_table[i].value, dir_table[i].kind, dir_table[i].typed);
    end

    // Random bursts of loads, each closed by a start
    while (items_sent < TOTAL_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        burst = 0;                                  // start on an empty store
      end else if (r <= 2) begin
        burst = MAX_REQ + $urandom_range(1, 3);     // overflow and drops
      end else if (r <= 4) begin
        burst = $urandom_range(9, MAX_REQ);
      end else begin
        burst = $urandom_range(1, 8);
      end
      base = $urandom_range(0, 127);
      for (int j = 0; j < burst; j++) begin
        // cluster some tracks round a base to provoke ties and duplicates
        if ($urandom_range(0, 2) == 0) begin
          v = base + $urandom_range(0, 4);
          if (v > 127) v = 127;
        end else begin
          v = $urandom_range(0, 127);
        end
        send_word(sstf_pkg::MODE_LOAD, v[TW-1:0], ROW_MODEL, none);
      end
      r = $urandom_range(0, 5);
      if (r == 0) begin
        head = '0;
      end else if (r == 1) begin
        head = '1;
      end else if (r == 2) begin
        head = base[TW-1:0];
      end else begin
        head = TW'($urandom_range(0, 127));
      end
      send_word(sstf_pkg::MODE_START, head, ROW_MODEL, none);
    end
    in_ch.valid <= 1'b0;

    // Drain: wait for every owed word, then watch for strays
    while (sched_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sched_expect.size() != 0) begin
      report_mismatch($sformatf("%0d schedule words never arrived", sched_expect.size()));
    end

    $display("Sent %0d words: %0d track loads and %0d schedule starts.",
             items_sent, loads_sent, starts_sent);
    $display("Checked %0d schedule words, %0d of them carrying the drop flag; %0d mismatches.",
             words_checked, drops_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_shortest_seek_first_scheduler_core: PASS");
    end else begin
      $display("tb_shortest_seek_first_scheduler_core: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/sstf_pkg.sv
sv/sstf_if.sv
sv/sstf_store.sv
sv/sstf_pick.sv
sv/shortest_seek_first_scheduler_core.sv
sv/sstf_checker.sv
sim/tb_shortest_seek_first_scheduler_core.sv
